@@ rtl/clt_pkg.sv @@
// Shared types and constants for the command line tokenizer.
// Depends on nothing; every file but clt_if imports it.
package clt_pkg;

    localparam int CHAR_W  = 8;
    localparam int KIND_W  = 3;
    localparam int COUNT_W = 8;

    // Result kinds
    localparam logic [KIND_W-1:0] KIND_BYTE   = 3'd0;
    localparam logic [KIND_W-1:0] KIND_END    = 3'd1;
    localparam logic [KIND_W-1:0] KIND_OK     = 3'd2;
    localparam logic [KIND_W-1:0] KIND_UNTERM = 3'd3;
    localparam logic [KIND_W-1:0] KIND_TRAIL  = 3'd4;

    // Special characters
    localparam logic [CHAR_W-1:0] CH_NUL  = 8'h00;
    localparam logic [CHAR_W-1:0] CH_SQ   = 8'h27;
    localparam logic [CHAR_W-1:0] CH_DQ   = 8'h22;
    localparam logic [CHAR_W-1:0] CH_BSL  = 8'h5C;
    localparam logic [CHAR_W-1:0] CH_SP   = 8'h20;
    localparam logic [CHAR_W-1:0] CH_TAB  = 8'h09;
    localparam logic [CHAR_W-1:0] CH_CR   = 8'h0D;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 8'hFF;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [CHAR_W-1:0]  char_out;
        logic               first_of_arg;
        logic [COUNT_W-1:0] arg_count;
        logic               last;
    } result_t;

    // One queue entry: the one or two results caused by one input byte.
    typedef struct packed {
        logic    two;
        result_t r0;
        result_t r1;
    } entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

@@ rtl/clt_if.sv @@
// Valid/ready channel interfaces for the tokenizer: input bytes and results.
// Depends on nothing.
interface clt_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;

    modport source (output valid, output ch, input ready);
    modport sink   (input valid, input ch, output ready);
endinterface

interface clt_token_if;
    logic       valid;
    logic       ready;
    logic [2:0] kind;
    logic [7:0] char_out;
    logic       first_of_arg;
    logic [7:0] arg_count;
    logic       last;

    modport source (output valid, output kind, output char_out, output first_of_arg,
                    output arg_count, output last, input ready);
    modport sink   (input valid, input kind, input char_out, input first_of_arg,
                    input arg_count, input last, output ready);
endinterface

@@ rtl/clt_front.sv @@
// Front end: quote/escape state machine; turns each byte that causes a result into a queue entry.
// Depends on clt_pkg.
module clt_front
    import clt_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                take,
    input  logic [CHAR_W-1:0]   ch,
    output logic                push,
    output entry_t              entry
);

    typedef enum logic [2:0] {
        M_NORMAL = 3'd0,
        M_BSLASH = 3'd1,
        M_SQUOTE = 3'd2,
        M_DQUOTE = 3'd3,
        M_DQ_BSL = 3'd4
    } mode_t;

    mode_t              mode_reg, mode_next;
    logic               started_reg, started_next;
    logic [COUNT_W-1:0] args_reg, args_next;
    logic [COUNT_W-1:0] args_inc;
    logic               is_ws;
    logic               has_res;

    assign args_inc = (args_reg == COUNT_MAX) ? COUNT_MAX : args_reg + 1'b1;
    assign is_ws    = (ch >= CH_TAB && ch <= CH_CR) || ch == CH_SP;

    always_comb
    begin
        mode_next    = mode_reg;
        started_next = started_reg;
        args_next    = args_reg;
        has_res      = 1'b0;
        entry        = '0;
        entry.r0.last = 1'b1;
        entry.r1.last = 1'b1;

        case (mode_reg)
            M_BSLASH:
            begin
                has_res = 1'b1;
                if (ch == CH_NUL)
                begin
                    entry.r0.kind = KIND_TRAIL;
                    mode_next     = M_NORMAL;
                    started_next  = 1'b0;
                    args_next     = '0;
                end
                else
                begin
                    entry.r0.kind         = KIND_BYTE;
                    entry.r0.char_out     = ch;
                    entry.r0.first_of_arg = !started_reg;
                    started_next          = 1'b1;
                    mode_next             = M_NORMAL;
                end
            end
            M_SQUOTE:
            begin
                if (ch == CH_NUL)
                begin
                    has_res       = 1'b1;
                    entry.r0.kind = KIND_UNTERM;
                    mode_next     = M_NORMAL;
                    started_next  = 1'b0;
                    args_next     = '0;
                end
                else if (ch == CH_SQ)
                    mode_next = M_NORMAL;
                else
                begin
                    has_res               = 1'b1;
                    entry.r0.kind         = KIND_BYTE;
                    entry.r0.char_out     = ch;
                    entry.r0.first_of_arg = !started_reg;
                    started_next          = 1'b1;
                end
            end
            M_DQUOTE:
            begin
                if (ch == CH_NUL)
                begin
                    has_res       = 1'b1;
                    entry.r0.kind = KIND_UNTERM;
                    mode_next     = M_NORMAL;
                    started_next  = 1'b0;
                    args_next     = '0;
                end
                else if (ch == CH_DQ)
                    mode_next = M_NORMAL;
                else if (ch == CH_BSL)
                    mode_next = M_DQ_BSL;
                else
                begin
                    has_res               = 1'b1;
                    entry.r0.kind         = KIND_BYTE;
                    entry.r0.char_out     = ch;
                    entry.r0.first_of_arg = !started_reg;
                    started_next          = 1'b1;
                end
            end
            M_DQ_BSL:
            begin
                has_res = 1'b1;
                if (ch == CH_NUL)
                begin
                    entry.r0.kind = KIND_UNTERM;
                    mode_next     = M_NORMAL;
                    started_next  = 1'b0;
                    args_next     = '0;
                end
                else
                begin
                    entry.r0.kind         = KIND_BYTE;
                    entry.r0.first_of_arg = !started_reg;
                    started_next          = 1'b1;
                    mode_next             = M_DQUOTE;
                    if (ch != CH_BSL && ch != CH_DQ)
                    begin
                        // escape not recognized: keep the backslash too
                        entry.two         = 1'b1;
                        entry.r0.char_out = CH_BSL;
                        entry.r0.last     = 1'b0;
                        entry.r1.kind     = KIND_BYTE;
                        entry.r1.char_out = ch;
                    end
                    else
                        entry.r0.char_out = ch;
                end
            end
            default:
            begin
                if (ch == CH_NUL)
                begin
                    has_res = 1'b1;
                    if (started_reg)
                    begin
                        entry.two          = 1'b1;
                        entry.r0.kind      = KIND_END;
                        entry.r0.last      = 1'b0;
                        entry.r1.kind      = KIND_OK;
                        entry.r1.arg_count = args_inc;
                    end
                    else
                    begin
                        entry.r0.kind      = KIND_OK;
                        entry.r0.arg_count = args_reg;
                    end
                    mode_next    = M_NORMAL;
                    started_next = 1'b0;
                    args_next    = '0;
                end
                else if (is_ws)
                begin
                    if (started_reg)
                    begin
                        has_res       = 1'b1;
                        entry.r0.kind = KIND_END;
                        started_next  = 1'b0;
                        args_next     = args_inc;
                    end
                end
                else if (ch == CH_SQ)
                    mode_next = M_SQUOTE;
                else if (ch == CH_DQ)
                    mode_next = M_DQUOTE;
                else if (ch == CH_BSL)
                    mode_next = M_BSLASH;
                else
                begin
                    has_res               = 1'b1;
                    entry.r0.kind         = KIND_BYTE;
                    entry.r0.char_out     = ch;
                    entry.r0.first_of_arg = !started_reg;
                    started_next          = 1'b1;
                end
            end
        endcase
    end

    assign push = take && has_res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= M_NORMAL;
            started_reg <= 1'b0;
            args_reg    <= '0;
        end
        else if (take)
        begin
            mode_reg    <= mode_next;
            started_reg <= started_next;
            args_reg    <= args_next;
        end
    end

endmodule

@@ rtl/clt_queue.sv @@
// Small flop-based FIFO of result entries between front and back ends.
// Depends on clt_pkg.
module clt_queue
    import clt_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  entry_t    push_data,
    input  logic      pop,
    output entry_t    head,
    output q_status_t status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    entry_t            mem_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              do_push, do_pop;

    assign status.full  = (count_reg == CNT_FULL);
    assign status.empty = (count_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign head         = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

endmodule

@@ rtl/clt_back.sv @@
// Back end: unpacks queue entries into single results on a registered output.
// Depends on clt_pkg.
module clt_back
    import clt_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  entry_t    head,
    input  q_status_t status,
    output logic      pop,
    input  logic      out_ready,
    output logic      out_valid,
    output result_t   out_res
);

    logic    out_valid_reg;
    logic    hold_valid_reg;
    result_t out_reg;
    result_t hold_reg;
    logic    load;

    // Output register may refill whenever it is empty or being drained.
    assign load      = !out_valid_reg || out_ready;
    assign pop       = load && !hold_valid_reg && !status.empty;
    assign out_valid = out_valid_reg;
    assign out_res   = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            hold_valid_reg <= 1'b0;
        end
        else if (load)
        begin
            if (hold_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                hold_valid_reg <= 1'b0;
            end
            else if (!status.empty)
            begin
                out_valid_reg  <= 1'b1;
                hold_valid_reg <= head.two;
            end
            else
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            if (hold_valid_reg)
                out_reg <= hold_reg;
            else if (!status.empty)
            begin
                out_reg  <= head.r0;
                hold_reg <= head.r1;
            end
        end
    end

endmodule

@@ rtl/command_line_tokenizer_core.sv @@
// Command line tokenizer: splits a NUL-terminated byte stream into arguments.
// Channel chars carries one line byte per request; byte 0 ends the line.
// Channel tokens carries results: argument bytes (first_of_arg marks the
// start of an argument), argument ends, and one line status per line:
// line ok with arg_count, unterminated quote, or trailing backslash.
// last is set on the final result caused by an input byte.
// Throughput: one input byte per cycle while the queue is not full and one
// result per cycle while tokens is ready. A byte that causes two results
// (unrecognized escape in double quotes, end of line with an open
// argument) occupies the output for both; the queue soaks that up. Bytes
// that cause no result (quotes, escapes, repeated spaces) are taken at the
// input and give nothing at the output. The front writes each result into
// the queue, and the back then loads it into the output register.
// Reset clears the quote/escape mode, argument state and queue; the output
// goes invalid. When tokens stalls, the queue fills and chars.ready drops
// once QUEUE_DEPTH entries wait; nothing is lost or reordered.
// Depends on clt_pkg, clt_if, clt_front, clt_queue, clt_back.
module command_line_tokenizer_core
    import clt_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic         clk,
    input  logic         rst_n,
    clt_char_if.sink     chars,
    clt_token_if.source  tokens
);

    entry_t    fe_entry;
    entry_t    q_head;
    q_status_t q_status;
    logic      fe_push;
    logic      be_pop;
    logic      take;
    result_t   res;

    // Front end stalls only when the queue is full.
    assign chars.ready = !q_status.full;
    assign take        = chars.valid && chars.ready;

    clt_front u_front
    (
        .clk   (clk),
        .rst_n (rst_n),
        .take  (take),
        .ch    (chars.ch),
        .push  (fe_push),
        .entry (fe_entry)
    );

    clt_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (fe_push),
        .push_data (fe_entry),
        .pop       (be_pop),
        .head      (q_head),
        .status    (q_status)
    );

    clt_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (q_head),
        .status    (q_status),
        .pop       (be_pop),
        .out_ready (tokens.ready),
        .out_valid (tokens.valid),
        .out_res   (res)
    );

    assign tokens.kind         = res.kind;
    assign tokens.char_out     = res.char_out;
    assign tokens.first_of_arg = res.first_of_arg;
    assign tokens.arg_count    = res.arg_count;
    assign tokens.last         = res.last;

endmodule
